>>> design/chth_pkg.sv
package chth_pkg;

  localparam int KEY_W     = 32;
  localparam int PAYLOAD_W = 16;
  localparam int PRIME_W   = 17;
  localparam int NUM_PRIMES = 10;

  typedef logic [PRIME_W-1:0] prime_t;

  localparam prime_t PRIMES [NUM_PRIMES] = '{
    17'd67, 17'd251, 17'd509, 17'd1021, 17'd2039,
    17'd4093, 17'd8191, 17'd16381, 17'd32749, 17'd65521
  };

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_FIND   = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FOUND    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_SWEEP, S_IDLE, S_HASH, S_HEAD, S_NODE, S_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    H_IDLE, H_ROUND, H_FIN, H_MOD
  } hash_state_t;

  // one result beat from the controller
  typedef struct packed {
    status_t                status;
    logic [PAYLOAD_W-1:0]   found_payload;
  } result_t;

  // first prime whose triple is above n, capped at the largest one fitting max_b
  function automatic prime_t pick_buckets(logic [15:0] n, int max_b);
    int i;
    i = 0;
    for (int k = 0; k < NUM_PRIMES - 1; k++) begin
      if (i == k && {1'b0, n} >= 17'(3 * PRIMES[k])) i = k + 1;
    end
    for (int k = NUM_PRIMES - 1; k > 0; k--) begin
      if (i == k && int'(PRIMES[k]) > max_b) i = k - 1;
    end
    return PRIMES[i];
  endfunction

endpackage

>>> design/chth_hash.sv
module chth_hash #(
  parameter int MAX_BUCKETS = 4096,
  parameter int KEY_BYTES   = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [chth_pkg::KEY_W-1:0]        key,
  input  logic [$clog2(MAX_BUCKETS+1)-1:0]  bucket_count,
  output logic                              done,
  output logic [$clog2(MAX_BUCKETS)-1:0]    bucket
);
  import chth_pkg::*;

  localparam int CW  = $clog2(MAX_BUCKETS + 1);
  localparam int BIW = $clog2(MAX_BUCKETS);

  hash_state_t state, state_next;
  logic [31:0]   h, h_round, h_fin;
  logic [31:0]   key_sr;
  logic [4:0]    cnt;
  logic [CW-1:0] rem, rem_next;
  logic [CW:0]   rem_sh;
  logic [31:0]   t1, t2, f1, f2;

  // one byte round of the one-at-a-time hash, sign-extended byte, and the final mix
  always_comb begin
    t1 = h + {{24{key_sr[7]}}, key_sr[7:0]};
    t2 = t1 + (t1 << 10);
    h_round = t2 ^ (t2 >> 6);
    f1 = h + (h << 3);
    f2 = f1 ^ (f1 >> 11);
    h_fin = f2 + (f2 >> 15);
  end

  // restoring remainder step, one hash bit per cycle
  always_comb begin
    rem_sh = {rem, h[31]};
    if (rem_sh >= {1'b0, bucket_count}) rem_next = CW'(rem_sh - {1'b0, bucket_count});
    else rem_next = rem_sh[CW-1:0];
  end

  always_comb begin
    state_next = state;
    done = 1'b0;
    unique case (state)
      H_IDLE:  if (start) state_next = H_ROUND;
      H_ROUND: if (cnt == 5'(KEY_BYTES - 1)) state_next = H_FIN;
      H_FIN:   state_next = H_MOD;
      H_MOD: begin
        if (cnt == 5'd31) begin
          state_next = H_IDLE;
          done = 1'b1;
        end
      end
      default: state_next = H_IDLE;
    endcase
  end

  assign bucket = rem_next[BIW-1:0];

  always_ff @(posedge clk) begin
    if (rst) state <= H_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      H_IDLE: begin
        h <= '0;
        key_sr <= key;
        cnt <= '0;
      end
      H_ROUND: begin
        h <= h_round;
        key_sr <= {8'd0, key_sr[31:8]};
        cnt <= (cnt == 5'(KEY_BYTES - 1)) ? 5'd0 : cnt + 5'd1;
      end
      H_FIN: begin
        h <= h_fin;
        rem <= '0;
        cnt <= '0;
      end
      default: begin
        rem <= rem_next;
        h <= {h[30:0], 1'b0};
        cnt <= cnt + 5'd1;
      end
    endcase
  end

  // done only ends a remainder pass
  a_done_mod: assert property (@(posedge clk) disable iff (rst)
    done |-> state == H_MOD) else $error("hash done outside remainder pass");
  // remainder stays below the bucket count
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == H_MOD && $past(state) == H_MOD) |-> rem < bucket_count)
    else $error("remainder out of range");
  // a start is only taken when idle
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (state == H_IDLE && start) |=> state == H_ROUND) else $error("start lost");

endmodule

>>> design/chth_ctrl.sv
module chth_ctrl #(
  parameter int MAX_BUCKETS = 4096,
  parameter int MAX_NODES   = 4096,
  parameter int KEY_BYTES   = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [$clog2(MAX_BUCKETS+1)-1:0]  bucket_count,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  chth_pkg::func_t                   item_func,
  input  logic [chth_pkg::KEY_W-1:0]        item_key,
  input  logic [chth_pkg::PAYLOAD_W-1:0]    item_payload,
  output logic                              res_valid,
  input  logic                              res_ready,
  output chth_pkg::result_t                 res
);
  import chth_pkg::*;

  localparam int BIW = $clog2(MAX_BUCKETS);
  localparam int NIW = $clog2(MAX_NODES);
  localparam int NUW = $clog2(MAX_NODES + 1);

  typedef struct packed {
    logic           valid;
    logic [NIW-1:0] idx;
  } head_t;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
    head_t                link;
  } node_t;

  head_t heads [MAX_BUCKETS];
  node_t nodes [MAX_NODES];

  ctrl_state_t state, state_next;
  func_t       func;
  logic [KEY_W-1:0]     key;
  logic [PAYLOAD_W-1:0] payload;
  logic [NUW-1:0]       nodes_used;
  logic [BIW-1:0]       sweep_cnt, bucket_r;
  logic                 clr_pend;
  head_t                head_q;
  node_t                node_q;
  result_t              res_r;
  logic                 hash_start, hash_done;
  logic [BIW-1:0]       hash_bucket;
  logic                 full, hit, take;

  chth_hash #(.MAX_BUCKETS(MAX_BUCKETS), .KEY_BYTES(KEY_BYTES)) u_hash (
    .clk, .rst, .start(hash_start), .key, .bucket_count,
    .done(hash_done), .bucket(hash_bucket)
  );

  assign full  = nodes_used == NUW'(MAX_NODES);
  assign hit   = node_q.key == key;
  assign take  = item_valid && item_ready;
  assign item_ready = state == S_IDLE;
  assign res_valid  = state == S_DONE;
  assign res = res_r;

  // next state
  always_comb begin
    state_next = state;
    hash_start = 1'b0;
    unique case (state)
      S_SWEEP: if (sweep_cnt == BIW'(MAX_BUCKETS - 1)) state_next = clr_pend ? S_DONE : S_IDLE;
      S_IDLE: begin
        if (take) begin
          state_next = S_DONE;
          if (item_func == FN_CLEAR) state_next = S_SWEEP;
          else if (item_func == FN_INSERT && !full) state_next = S_HASH;
          else if (item_func == FN_FIND && item_key != '1) state_next = S_HASH;
        end
      end
      S_HASH: begin
        hash_start = 1'b1;
        if (hash_done) state_next = S_HEAD;
      end
      S_HEAD: state_next = (func == FN_FIND && head_q.valid) ? S_NODE : S_DONE;
      S_NODE: if (hit || !node_q.link.valid) state_next = S_DONE;
      S_DONE: if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (cfg_we) state_next = S_SWEEP;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_SWEEP;
    else state <= state_next;
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      sweep_cnt <= '0;
      clr_pend <= 1'b0;
      nodes_used <= '0;
    end else begin
      if (state == S_SWEEP) sweep_cnt <= sweep_cnt + 1'b1;
      if (state == S_IDLE && take && item_func == FN_CLEAR) begin
        clr_pend <= 1'b1;
        sweep_cnt <= '0;
        nodes_used <= '0;
      end
      if (state == S_DONE) clr_pend <= 1'b0;
      if (state == S_HEAD && func == FN_INSERT) nodes_used <= nodes_used + 1'b1;
    end
  end

  // item latch and result
  always_ff @(posedge clk) begin
    if (take) begin
      func <= item_func;
      key <= item_key;
      payload <= item_payload;
      res_r.found_payload <= '0;
      if (item_func == FN_INSERT && full) res_r.status <= ST_FULL;
      else if (item_func == FN_INSERT || item_func == FN_CLEAR) res_r.status <= ST_OK;
      else res_r.status <= ST_NOTFOUND;
    end
    if (state == S_NODE && hit) begin
      res_r.status <= ST_FOUND;
      res_r.found_payload <= node_q.payload;
    end
    if (state == S_HASH && hash_done) bucket_r <= hash_bucket;
  end

  // bucket head memory: sweep or insert write, read after hashing
  always_ff @(posedge clk) begin
    if (state == S_SWEEP) heads[sweep_cnt] <= '0;
    else if (state == S_HEAD && func == FN_INSERT)
      heads[bucket_r] <= '{valid: 1'b1, idx: nodes_used[NIW-1:0]};
    if (state == S_HASH && hash_done) head_q <= heads[hash_bucket];
  end

  // node memory: push on insert, chain walk on find
  always_ff @(posedge clk) begin
    if (state == S_HEAD && func == FN_INSERT)
      nodes[nodes_used[NIW-1:0]] <= '{key: key, payload: payload, link: head_q};
    if (state == S_HEAD) node_q <= nodes[head_q.idx];
    else if (state == S_NODE) node_q <= nodes[node_q.link.idx];
  end

  a_used_cap: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= NUW'(MAX_NODES)) else $error("node count beyond pool");
  a_insert_inc: assert property (@(posedge clk) disable iff (rst)
    (state == S_HEAD && func == FN_INSERT && !cfg_we) |=>
      nodes_used == $past(nodes_used) + 1'b1) else $error("insert did not allocate");
  a_hash_in_hash: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> state == S_HASH) else $error("stray hash result");

endmodule

>>> design/chained_hash_table_address_keys_unit.sv
// channel | dir | signals                       | contents
// s       | in  | s_tvalid s_tready s_tdata/user | key, payload / func
// m       | out | m_tvalid m_tready m_tdata/user | found_payload / status
// cfg     | in  | cfg_valid cfg_ready cfg_data   | expected_entries
//
// Find walks the bucket chain node by node after hashing; the 32-step bucket
// remainder in the hash unit sets most of the time an insert or find takes.
// Reset, a config write and a clear each sweep all MAX_BUCKETS entries of the
// bucket head memory; no beat is taken meanwhile (clear returns its beat after).
// A waiting result sits in the output register while the next beat is taken.
module chained_hash_table_address_keys_unit #(
  parameter int MAX_BUCKETS = 4096,
  parameter int MAX_NODES   = 4096,
  parameter int KEY_BYTES   = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // key[31:0], payload[47:32]
  input  logic [1:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // found_payload
  output logic [1:0]  m_tuser,   // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import chth_pkg::*;

  localparam int CW = $clog2(MAX_BUCKETS + 1);

  logic [CW-1:0] bucket_count;
  logic          cfg_we, res_valid, res_ready;
  result_t       res;

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && cfg_ready;

  // bucket count register
  always_ff @(posedge clk) begin
    if (rst) bucket_count <= CW'(pick_buckets(16'd0, MAX_BUCKETS));
    else if (cfg_we) bucket_count <= CW'(pick_buckets(cfg_data, MAX_BUCKETS));
  end

  chth_ctrl #(.MAX_BUCKETS(MAX_BUCKETS), .MAX_NODES(MAX_NODES), .KEY_BYTES(KEY_BYTES)) u_ctrl (
    .clk, .rst, .cfg_we, .bucket_count,
    .item_valid(s_tvalid), .item_ready(s_tready),
    .item_func(func_t'(s_tuser)), .item_key(s_tdata[31:0]), .item_payload(s_tdata[47:32]),
    .res_valid, .res_ready, .res
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (res_ready) m_tvalid <= res_valid;
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= res.found_payload;
      m_tuser <= res.status;
    end
  end

endmodule

>>> dv/tb_chained_hash_table_address_keys_unit.sv
`timescale 1ns / 1ps

module tb_chained_hash_table_address_keys_unit;
  import chth_pkg::*;

  localparam int NBUCK = 4096;
  localparam int NNODE = 4096;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct packed {
    status_t     status;
    logic [15:0] payload;
  } lookup_t;

  // shadow copy of the table, predicts the answer of every operation
  class hash_table_sb;
    int unsigned buckets;
    bit          head_ok [NBUCK];
    int unsigned head    [NBUCK];
    logic [31:0] nkey    [NNODE];
    logic [15:0] npay    [NNODE];
    bit          link_ok [NNODE];
    int unsigned link    [NNODE];
    int unsigned used;
    lookup_t     pending [$];
    int          errors;

    function void wipe();
      for (int i = 0; i < NBUCK; i++) head_ok[i] = 0;
      used = 0;
    endfunction

    function void set_size(logic [15:0] n);
      int unsigned primes [10] = '{67, 251, 509, 1021, 2039, 4093, 8191, 16381,
                                   32749, 65521};
      int i;
      i = 0;
      while (i < 9 && primes[i] <= n / 3) i++;
      while (i > 0 && primes[i] > NBUCK) i--;
      buckets = primes[i];
      wipe();
    endfunction

    // one-at-a-time rounds over the key bytes, low byte first, bytes sign-extended, then the final mix
    function int unsigned bucket_for(logic [31:0] k);
      logic [31:0] h;
      h = 0;
      for (int i = 0; i < 4; i++) begin
        h += {{24{k[8*i+7]}}, k[8*i +: 8]};
        h += h << 10;
        h ^= h >> 6;
      end
      h += h << 3;
      h ^= h >> 11;
      h += h >> 15;
      return h % buckets;
    endfunction

    function void note_op(func_t f, logic [31:0] k, logic [15:0] p);
      lookup_t r;
      int unsigned b, n, steps;
      bit v;
      r.status = ST_NOTFOUND;
      r.payload = 0;
      if (f == FN_INSERT) begin
        if (used >= NNODE) r.status = ST_FULL;
        else begin
          b = bucket_for(k);
          nkey[used] = k;
          npay[used] = p;
          link_ok[used] = head_ok[b];
          link[used] = head[b];
          head_ok[b] = 1;
          head[b] = used;
          used++;
          r.status = ST_OK;
        end
      end else if (f == FN_FIND) begin
        if (k != 32'hFFFF_FFFF) begin
          b = bucket_for(k);
          v = head_ok[b];
          n = head[b];
          steps = 0;
          while (v && steps < NNODE) begin
            if (nkey[n] == k) begin
              r.status = ST_FOUND;
              r.payload = npay[n];
              break;
            end
            v = link_ok[n];
            n = link[n];
            steps++;
          end
        end
      end else if (f == FN_CLEAR) begin
        wipe();
        r.status = ST_OK;
      end
      pending.push_back(r);
    endfunction

    function void check_beat(logic [1:0] st, logic [15:0] pay);
      lookup_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing outstanding: status %0d", st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (pay !== e.payload) begin
        $error("found_payload: expected %0h, got %0h", e.payload, pay);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [47:0] s_tdata = 0;
  logic [1:0]  s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 0;

  hash_table_sb sb;
  int send_idle_pct, recv_idle_pct;
  int cycles;
  logic [31:0] known_keys [$];

  always #1 clk = ~clk;

  chained_hash_table_address_keys_unit dut (.*);

  // result side: random stall, check on accepted beats
  always @(negedge clk) m_tready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  always @(posedge clk) if (!rst && m_tvalid && m_tready) sb.check_beat(m_tuser, m_tdata);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // valid stays up after a beat until the next op or an idle cycle drops it
  task automatic send_op(func_t f, logic [31:0] k, logic [15:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= f;
    s_tdata <= {p, k};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_op(f, k, p);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_size(logic [15:0] n);
    drain();
    cfg_valid <= 1;
    cfg_data <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_size(n);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] pick_key();
    if (known_keys.size() != 0 && $urandom_range(99) < 55)
      return known_keys[$urandom_range(known_keys.size() - 1)];
    return $urandom_range(3) == 0 ? 32'(32'h8080_0000 | $urandom_range(255)) : $urandom;
  endfunction

  task automatic random_ops(int count);
    int r;
    logic [31:0] k;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      k = pick_key();
      if (r < 45) begin
        send_op(FN_INSERT, k, 16'($urandom));
        known_keys.push_back(k);
      end else if (r < 92) send_op(FN_FIND, k, 16'($urandom));
      else if (r < 95) send_op(FN_NONE, k, 16'($urandom));
      else if (r < 97) send_op(FN_FIND, 32'hFFFF_FFFF, 16'($urandom));
      else begin
        send_op(FN_CLEAR, k, 16'($urandom));
        known_keys.delete();
      end
    end
  endtask

  initial begin
    sb = new();
    sb.set_size(0);
    send_idle_pct = 11;
    recv_idle_pct = 75;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes, duplicates, all-ones key, unused code, clear
    send_op(FN_FIND, 32'h0, 16'h0);
    send_op(FN_INSERT, 32'h0, 16'hFFFF);
    send_op(FN_INSERT, 32'hFFFF_FFFF, 16'h0);
    send_op(FN_INSERT, 32'h8080_8080, 16'h1234);
    send_op(FN_INSERT, 32'h8080_8080, 16'hABCD);
    send_op(FN_FIND, 32'h8080_8080, 16'h0);
    send_op(FN_FIND, 32'h0, 16'h0);
    send_op(FN_FIND, 32'hFFFF_FFFF, 16'h0);
    send_op(FN_FIND, 32'h7F7F_7F7F, 16'h0);
    send_op(FN_NONE, 32'h0, 16'hFFFF);
    send_op(FN_CLEAR, 32'h0, 16'h0);
    send_op(FN_FIND, 32'h0, 16'h0);
    write_size(16'hFFFF);
    send_op(FN_INSERT, 32'h1234_5678, 16'h5555);
    send_op(FN_FIND, 32'h1234_5678, 16'h0);
    send_op(FN_FIND, 32'hEDCB_A987, 16'h0);
    write_size(16'd201);
    send_op(FN_INSERT, 32'h0000_00FF, 16'h00AA);
    send_op(FN_FIND, 32'h0000_00FF, 16'h0);

    random_ops(400);
    write_size(16'd12000);
    known_keys.delete();
    send_idle_pct = 75;
    recv_idle_pct = 11;
    random_ops(400);
    write_size(16'd2000);
    known_keys.delete();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_ops(300);

    // smallest table again, long chains per bucket
    write_size(16'd0);
    known_keys.delete();
    random_ops(300);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
